// File: rtl/ctd_pkg.sv
// shared types and constants for the chunked transfer decoder
package ctd_pkg;

	// default sizes handed to the top level parameters
	localparam int DEF_COUNT_WIDTH = 32;
	localparam int DEF_MAX_DIGITS  = 8;

	// entries in the queue between classifier and sequencer
	localparam int QUEUE_DEPTH = 4;

	// byte classes seen by the sequencer
	localparam logic [1:0] CLS_DIGIT = 2'd0;
	localparam logic [1:0] CLS_CR    = 2'd1;
	localparam logic [1:0] CLS_LF    = 2'd2;
	localparam logic [1:0] CLS_OTHER = 2'd3;

	// one classified request
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] cls;
		logic [3:0] dval;
	} ctd_entry_t;

endpackage

// File: rtl/ctd_front.sv
// front end: size radix register and byte classifier
module ctd_front import ctd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic [7:0] in_byte,
	output logic       hex_sizes,
	output ctd_entry_t entry
);

	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_9  = 8'h39;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LF = 8'h66;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;
	localparam logic [7:0] BYTE_CR = 8'h0d;
	localparam logic [7:0] BYTE_LF = 8'h0a;
	localparam logic [7:0] TEN     = 8'd10;

	logic       hex_q;
	logic [7:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_q <= 1'b1;
		end else if (cfg_wr_en) begin
			hex_q <= cfg_wr_data;
		end
	end

	assign hex_sizes = hex_q;

	always_comb begin
		diff       = 8'd0;
		entry.data = in_byte;
		entry.cls  = CLS_OTHER;
		if (in_byte inside {[CHAR_0:CHAR_9]}) begin
			entry.cls = CLS_DIGIT;
			diff      = in_byte - CHAR_0;
		end else if (hex_q && (in_byte inside {[CHAR_LA:CHAR_LF]})) begin
			entry.cls = CLS_DIGIT;
			diff      = in_byte - CHAR_LA + TEN;
		end else if (hex_q && (in_byte inside {[CHAR_UA:CHAR_UF]})) begin
			entry.cls = CLS_DIGIT;
			diff      = in_byte - CHAR_UA + TEN;
		end else if (in_byte == BYTE_CR) begin
			entry.cls = CLS_CR;
		end else if (in_byte == BYTE_LF) begin
			entry.cls = CLS_LF;
		end
		entry.dval = diff[3:0];
	end

endmodule

// File: rtl/ctd_queue.sv
// small fifo between classifier and sequencer
module ctd_queue import ctd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ctd_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output logic       nonempty,
	output ctd_entry_t rd_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ctd_entry_t       store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_entry = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/ctd_back.sv
// back end: framing sequencer, size accumulator and output register
module ctd_back import ctd_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hex_sizes,
	input  logic       q_nonempty,
	input  ctd_entry_t q_entry,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       chunk_end
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	localparam logic [2:0] PH_SIZE    = 3'd0;
	localparam logic [2:0] PH_SIZE_LF = 3'd1;
	localparam logic [2:0] PH_DATA    = 3'd2;
	localparam logic [2:0] PH_DATA_CR = 3'd3;
	localparam logic [2:0] PH_DATA_LF = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;
	localparam logic [2:0] PH_ERROR   = 3'd6;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	logic [2:0]             phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] left_q, left_d;
	logic [CNT_W-1:0]       digits_q, digits_d;
	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic [1:0]             kind_q;
	logic                   chunk_end_q;

	logic                   emit;
	logic [7:0]             emit_byte;
	logic [1:0]             emit_kind;
	logic                   emit_last;
	logic [COUNT_WIDTH-1:0] scaled;
	logic [COUNT_WIDTH-1:0] left_dec;

	assign q_pop = q_nonempty && (!out_valid_q || out_ready);

	// times 16 or times 10 by shifts
	assign scaled   = hex_sizes ? (left_q << 4) : ((left_q << 3) + (left_q << 1));
	assign left_dec = left_q - 1'b1;

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		digits_d  = digits_q;
		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_kind = KIND_PAYLOAD;
		emit_last = 1'b0;
		case (phase_q)
			PH_SIZE: begin
				if (q_entry.cls == CLS_DIGIT) begin
					if (digits_q >= CNT_W'(MAX_DIGITS)) begin
						phase_d   = PH_ERROR;
						emit      = 1'b1;
						emit_kind = KIND_ERROR;
					end else begin
						left_d   = scaled + {{(COUNT_WIDTH-4){1'b0}}, q_entry.dval};
						digits_d = digits_q + 1'b1;
					end
				end else if (q_entry.cls == CLS_CR && digits_q != '0) begin
					phase_d = PH_SIZE_LF;
				end else begin
					phase_d   = PH_ERROR;
					emit      = 1'b1;
					emit_kind = KIND_ERROR;
				end
			end
			PH_SIZE_LF: begin
				if (q_entry.cls != CLS_LF) begin
					phase_d   = PH_ERROR;
					emit      = 1'b1;
					emit_kind = KIND_ERROR;
				end else begin
					digits_d = '0;
					if (left_q == '0) begin
						phase_d   = PH_DONE;
						emit      = 1'b1;
						emit_kind = KIND_END;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				left_d    = left_dec;
				emit      = 1'b1;
				emit_byte = q_entry.data;
				if (left_dec == '0) begin
					phase_d   = PH_DATA_CR;
					emit_last = 1'b1;
				end
			end
			PH_DATA_CR: begin
				if (q_entry.cls != CLS_CR) begin
					phase_d   = PH_ERROR;
					emit      = 1'b1;
					emit_kind = KIND_ERROR;
				end else begin
					phase_d = PH_DATA_LF;
				end
			end
			PH_DATA_LF: begin
				if (q_entry.cls != CLS_LF) begin
					phase_d   = PH_ERROR;
					emit      = 1'b1;
					emit_kind = KIND_ERROR;
				end else begin
					phase_d  = PH_SIZE;
					left_d   = '0;
					digits_d = '0;
				end
			end
			default: begin
				// ended or failed: swallow everything
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			left_q      <= '0;
			digits_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q  <= phase_d;
				left_q   <= left_d;
				digits_q <= digits_d;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_byte_q  <= emit_byte;
			kind_q      <= emit_kind;
			chunk_end_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign kind      = kind_q;
	assign chunk_end = chunk_end_q;

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("payload phase with zero bytes left");

	a_digits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond limit");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE || phase_q == PH_ERROR |=> $stable(phase_q))
		else $error("left a terminal phase");

	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && chunk_end_q |-> kind_q == KIND_PAYLOAD)
		else $error("chunk end flag on a non-payload result");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !q_pop)
		else $error("queue popped while output stalled");

endmodule

// File: rtl/chunked_transfer_decoder_top.sv
// top level of the chunked transfer decoder
// Decodes a chunked-encoded body one byte per request. Each chunk opens with a
// size line of digits ended by CR LF (hex when hex_sizes is 1, the reset value,
// decimal when 0); that many payload bytes then come out with kind 0, the last
// one with chunk_end set, and the CR LF after the data is swallowed. A size of
// zero gives one end-of-stream result (kind 1); a malformed byte, an empty size
// line or more than MAX_DIGITS digits gives one error result (kind 2). After an
// end or an error every byte is taken and dropped until reset. Sizes wrap at
// COUNT_WIDTH bits. Throughput is one byte per clock while out_ready keeps the
// output draining: the classifier pushes each accepted byte into a four-entry
// queue in the cycle it is taken, and the sequencer pops one entry per clock
// whenever the output register is free or being drained, so each result passes
// through the queue and then the output register. in_ready drops only when the
// queue is full. Write hex_sizes only while no bytes are in flight.
module chunked_transfer_decoder_top import ctd_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	// byte requests in
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	// results out
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       chunk_end
);

	ctd_entry_t front_entry;
	ctd_entry_t q_entry;
	logic       q_full;
	logic       q_nonempty;
	logic       q_pop;
	logic       hex_sizes;

	// classifier also owns the radix register
	ctd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_byte     (in_byte),
		.hex_sizes   (hex_sizes),
		.entry       (front_entry)
	);

	assign in_ready = !q_full;

	ctd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && in_ready),
		.wr_entry (front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd_entry (q_entry)
	);

	// radix for the size accumulator; the digit values already follow it, and the user
	// must make config changes only while the queue is empty; the block does not check
	ctd_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hex_sizes  (hex_sizes),
		.q_nonempty (q_nonempty),
		.q_entry    (q_entry),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.chunk_end  (chunk_end)
	);

endmodule
